// File: sv/lpcm_pkg.sv
// Shared types and constants of the looping PCM channel mixer.
package lpcm_pkg;

  // Transaction opcodes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_PLAY       = 3'd1,
    MODE_STOP_CHAN  = 3'd2,
    MODE_STOP_SOUND = 3'd3,
    MODE_STOP_ALL   = 3'd4,
    MODE_QUERY      = 3'd5,
    MODE_LOAD       = 3'd6
  } mode_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_VOLUME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE       = 1'd1;

  localparam logic [7:0] VOL_RESET   = 8'd128;
  localparam logic [7:0] SAMPLE_BIAS = 8'h80;
  localparam int unsigned VOL_SHIFT  = 7;
  localparam int signed CLAMP_HI     = 127;
  localparam int signed CLAMP_LO     = -128;
  localparam logic signed [2:0] TAKEN_NONE = -3'sd1;

  typedef struct packed {
    logic [2:0]        mode;
    logic [15:0]       sound_start;
    logic [15:0]       sound_length;
    logic signed [7:0] loop_count;
    logic [1:0]        channel_index;
    logic [15:0]       sample_address;
    logic [7:0]        sample_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic signed [2:0]  channel_taken;
    logic               sound_playing;
  } out_item_t;

endpackage

// File: sv/looping_pcm_channel_mixer.sv
// Top level of the looping PCM channel mixer: sequencer, channel registers and mix scaling.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one command per
//   transaction: tick, play, stop channel, stop sound, stop all, query or load byte.
//   Every command returns exactly one result transaction on the output channel
//   (out_valid_o / out_ready_i / out_data_o); fields a command does not produce are 0.
//   The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes mix volume
//   and mute; write it only while no command is in flight.
//   Timing: a single sequencer steps over the channels one at a time, so the block
//   takes one command at a time. A tick only decides on an idle channel; on an active
//   channel it decides, folds the address, reads sample memory and accumulates; then
//   it does the volume multiply, scale/clamp and hand-off. Play scans the channels for
//   one already playing the sound or else the first free one; stop sound, stop all and
//   query visit every channel; stop channel visits one; load byte folds and writes.
//   The output register lets a new command be accepted while a result is still
//   waiting; if the receiver stalls, the next result holds in the hand-off state.
//   Reset frees every channel, sets volume to 128 and clears mute. Sample memory
//   is not cleared: load every byte a sound uses before playing it.
module looping_pcm_channel_mixer #(
  parameter int CHANNELS     = 4,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lpcm_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lpcm_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [lpcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpcm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW     = $clog2(SAMPLE_DEPTH);
  localparam int ACC_W  = $clog2(CHANNELS) + 9;
  localparam int PROD_W = ACC_W + 9;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic signed [PROD_W-1:0] CLAMP_HI = PROD_W'(lpcm_pkg::CLAMP_HI);
  localparam logic signed [PROD_W-1:0] CLAMP_LO = PROD_W'(lpcm_pkg::CLAMP_LO);
  localparam logic signed [ACC_W-1:0]  ACC_HI   = ACC_W'(127 * CHANNELS);
  localparam logic signed [ACC_W-1:0]  ACC_LO   = ACC_W'(-128 * CHANNELS);

  // Sequencer states.
  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_TICK   = 12'b0000_0000_0010,
    S_FOLD   = 12'b0000_0000_0100,
    S_IDX    = 12'b0000_0000_1000,
    S_ACC    = 12'b0000_0001_0000,
    S_MUL    = 12'b0000_0010_0000,
    S_SCALE  = 12'b0000_0100_0000,
    S_PLAY   = 12'b0000_1000_0000,
    S_PLWR   = 12'b0001_0000_0000,
    S_SCAN   = 12'b0010_0000_0000,
    S_STOPCH = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  // Per-channel playback context.
  typedef struct packed {
    logic signed [7:0] loops;
    logic              assigned;
    logic [15:0]       start;
    logic [15:0]       length;
    logic [15:0]       raddr;
    logic [15:0]       left;
  } chan_t;

  state_e state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic [CH_W-1:0] pick_q, pick_d;
  logic have_q, have_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  lpcm_pkg::in_item_t  req_q, req_d;
  lpcm_pkg::out_item_t res_q, res_d;
  lpcm_pkg::out_item_t out_data_q, out_data_d;
  logic out_valid_q, out_valid_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0] vol_q;
  logic mute_q;

  chan_t chan_q [CHANNELS];
  chan_t cur;
  chan_t chan_wdata;
  logic chan_we;
  logic [CH_W-1:0] chan_widx;

  logic [AW-1:0] ram_idx;
  logic [7:0] ram_rdata;
  logic ram_we;

  logic signed [7:0] smp;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] scaled;
  logic signed [7:0] clamped;
  logic [CH_W+2:0] pick_ext;
  logic chan_ok;
  logic snd_match;

  assign cur       = chan_q[ch_q];
  assign smp       = $signed(ram_rdata ^ lpcm_pkg::SAMPLE_BIAS);
  assign pick_ext  = {3'b000, pick_q};
  assign chan_ok   = int'(in_data_i.channel_index) < CHANNELS;
  assign snd_match = cur.assigned && (cur.start == req_q.sound_start);

  // Scale by volume/128 truncating toward zero, then clamp to 8 bits.
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'(127) : PROD_W'(0));
  assign scaled   = prod_adj >>> lpcm_pkg::VOL_SHIFT;
  always_comb begin
    if (scaled > CLAMP_HI) begin
      clamped = 8'(CLAMP_HI);
    end else if (scaled < CLAMP_LO) begin
      clamped = 8'(CLAMP_LO);
    end else begin
      clamped = scaled[7:0];
    end
  end

  lpcm_addr_fold #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_fold (
    .clk_i (clk_i),
    .addr_i(addr_q),
    .idx_o (ram_idx)
  );

  lpcm_ram #(
    .WIDTH(8),
    .DEPTH(SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_idx),
    .wdata_i(req_q.sample_byte),
    .rdata_o(ram_rdata)
  );

  // Sequencer.
  always_comb begin
    logic signed [7:0] loops_nx;
    state_d     = state_q;
    ch_d        = ch_q;
    pick_d      = pick_q;
    have_d      = have_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    req_d       = req_q;
    res_d       = res_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    chan_we     = 1'b0;
    chan_widx   = ch_q;
    chan_wdata  = cur;
    ram_we      = 1'b0;
    loops_nx    = (cur.loops > 8'sd0) ? (cur.loops - 8'sd1) : cur.loops;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          ch_d   = '0;
          pick_d = '0;
          have_d = 1'b0;
          acc_d  = '0;
          res_d  = '0;
          addr_d = in_data_i.sample_address;
          unique case (in_data_i.mode) inside
            lpcm_pkg::MODE_TICK: state_d = S_TICK;
            lpcm_pkg::MODE_PLAY: begin
              if (in_data_i.sound_length == 16'd0) begin
                res_d.channel_taken = lpcm_pkg::TAKEN_NONE;
                state_d = S_DONE;
              end else begin
                state_d = S_PLAY;
              end
            end
            lpcm_pkg::MODE_STOP_CHAN: begin
              if (chan_ok) begin
                ch_d    = CH_W'(in_data_i.channel_index);
                state_d = S_STOPCH;
              end else begin
                state_d = S_DONE;
              end
            end
            lpcm_pkg::MODE_STOP_SOUND, lpcm_pkg::MODE_STOP_ALL,
            lpcm_pkg::MODE_QUERY: state_d = S_SCAN;
            lpcm_pkg::MODE_LOAD: state_d = S_FOLD;
            default: state_d = S_DONE;
          endcase
        end
      end

      S_TICK: begin
        if (cur.loops == 8'sd0) begin
          if (ch_q == LAST_CH) begin
            state_d = S_MUL;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end else if (cur.left != 16'd0) begin
          addr_d           = cur.raddr;
          chan_we          = 1'b1;
          chan_wdata.raddr = cur.raddr + 16'd1;
          chan_wdata.left  = cur.left - 16'd1;
          state_d          = S_FOLD;
        end else if (loops_nx != 8'sd0 && cur.length != 16'd0) begin
          // End of a pass: reload the sound and fetch its first byte.
          addr_d           = cur.start;
          chan_we          = 1'b1;
          chan_wdata.loops = loops_nx;
          chan_wdata.raddr = cur.start + 16'd1;
          chan_wdata.left  = cur.length - 16'd1;
          state_d          = S_FOLD;
        end else begin
          chan_we    = 1'b1;
          chan_wdata = '0;
          if (ch_q == LAST_CH) begin
            state_d = S_MUL;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end

      S_FOLD: state_d = S_IDX;

      S_IDX: begin
        if (req_q.mode == lpcm_pkg::MODE_LOAD) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_ACC;
        end
      end

      S_ACC: begin
        acc_d = acc_q + ACC_W'(smp);
        if (ch_q == LAST_CH) begin
          state_d = S_MUL;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_TICK;
        end
      end

      S_MUL: begin
        prod_d  = PROD_W'(acc_q) * PROD_W'($signed({1'b0, vol_q}));
        state_d = S_SCALE;
      end

      S_SCALE: begin
        res_d.mixed_sample = mute_q ? 16'sd0 : $signed({clamped, 8'h00});
        state_d = S_DONE;
      end

      S_PLAY: begin
        if (cur.loops != 8'sd0 && snd_match) begin
          // Restart the channel already playing this sound.
          pick_d  = ch_q;
          have_d  = 1'b1;
          state_d = S_PLWR;
        end else begin
          if (cur.loops == 8'sd0 && !have_q) begin
            pick_d = ch_q;
            have_d = 1'b1;
          end
          if (ch_q == LAST_CH) begin
            if (have_d) begin
              state_d = S_PLWR;
            end else begin
              res_d.channel_taken = lpcm_pkg::TAKEN_NONE;
              state_d = S_DONE;
            end
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end

      S_PLWR: begin
        chan_we             = 1'b1;
        chan_widx           = pick_q;
        chan_wdata.loops    = req_q.loop_count;
        chan_wdata.assigned = 1'b1;
        chan_wdata.start    = req_q.sound_start;
        chan_wdata.length   = req_q.sound_length;
        chan_wdata.raddr    = req_q.sound_start;
        chan_wdata.left     = req_q.sound_length;
        res_d.channel_taken = $signed(pick_ext[2:0]);
        state_d             = S_DONE;
      end

      S_SCAN: begin
        case (req_q.mode)
          lpcm_pkg::MODE_STOP_SOUND: begin
            if (snd_match) begin
              chan_we    = 1'b1;
              chan_wdata = '0;
            end
          end
          lpcm_pkg::MODE_STOP_ALL: begin
            chan_we    = 1'b1;
            chan_wdata = '0;
          end
          lpcm_pkg::MODE_QUERY: begin
            if (snd_match) begin
              res_d.sound_playing = 1'b1;
            end
          end
          default: ;
        endcase
        if (ch_q == LAST_CH) begin
          state_d = S_DONE;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end

      S_STOPCH: begin
        if (cur.assigned) begin
          chan_we    = 1'b1;
          chan_wdata = '0;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hand off to the output register once it is free or draining.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      pick_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      vol_q       <= lpcm_pkg::VOL_RESET;
      mute_q      <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      pick_q      <= pick_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      if (chan_we) begin
        chan_q[chan_widx] <= chan_wdata;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lpcm_pkg::CFG_MIX_VOLUME: vol_q  <= cfg_data_i;
          lpcm_pkg::CFG_MUTE:       mute_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    req_q      <= req_d;
    res_q      <= res_d;
    addr_q     <= addr_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Assertions.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a transaction but stayed ready");

  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && out_valid_q && !out_ready_i |=>
      (state_q == S_DONE) && $stable(res_q))
    else $error("pending result lost while output stalled");

  a_acc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (acc_q >= ACC_LO) && (acc_q <= ACC_HI))
    else $error("mix accumulator out of range");

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
    a_free_is_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
      !chan_q[c].assigned |-> (chan_q[c].loops == 8'sd0) && (chan_q[c].left == 16'd0))
      else $error("unassigned channel still holds playback state");
  end

endmodule

// File: sv/lpcm_ram.sv
// Generic single-port RAM with registered read data.
module lpcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lpcm_addr_fold.sv
// Reduces a 16-bit sample address modulo the sample memory depth.
module lpcm_addr_fold #(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                            clk_i,
  input  logic [15:0]                     addr_i,
  output logic [$clog2(SAMPLE_DEPTH)-1:0] idx_o
);

  localparam int AW = $clog2(SAMPLE_DEPTH);

  if (SAMPLE_DEPTH < 65536) begin : g_fold
    // Estimate the quotient with a fixed-point reciprocal; it is low by at most one.
    localparam longint RECIP_L = (64'd1 << 32) / SAMPLE_DEPTH;
    localparam logic [24:0] RECIP   = 25'(RECIP_L);
    localparam logic [15:0] DEPTH16 = 16'(SAMPLE_DEPTH);

    logic [40:0] quo_full;
    logic [7:0]  quo_q;
    logic [23:0] quo_depth;
    logic [15:0] rem_raw;
    logic [15:0] rem;

    assign quo_full = 41'(addr_i) * 41'(RECIP);

    always_ff @(posedge clk_i) begin
      quo_q <= quo_full[39:32];
    end

    assign quo_depth = 24'(quo_q) * 24'(DEPTH16);
    assign rem_raw   = addr_i - quo_depth[15:0];
    assign rem       = (rem_raw >= DEPTH16) ? (rem_raw - DEPTH16) : rem_raw;
    assign idx_o     = AW'(rem);
  end else begin : g_pass
    logic [AW-1:0] idx_q;

    always_ff @(posedge clk_i) begin
      idx_q <= AW'(addr_i);
    end

    assign idx_o = idx_q;
  end

endmodule
